[sv/stable_priority_request_dispatcher_top_macros.svh]
// Assertion macros for the stable priority request dispatcher.
// Included by modules that carry concurrent checks; expects clk and rst_n in scope.

`ifndef STABLE_PRIORITY_REQUEST_DISPATCHER_TOP_MACROS_SVH
`define STABLE_PRIORITY_REQUEST_DISPATCHER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define SPD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define SPD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/spd_pkg.sv]
// Shared types and constants for the stable priority request dispatcher.
// No dependencies; used by spd_cell, spd_row and the top level.

package spd_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PRIO_W      = 8;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [PRIO_W-1:0] prio_t;
    typedef logic [7:0]        tag_t;

    // Request modes
    localparam logic [2:0] MODE_ENQUEUE    = 3'd0;
    localparam logic [2:0] MODE_FINISH     = 3'd1;
    localparam logic [2:0] MODE_CANCEL_ALL = 3'd2;
    localparam logic [2:0] MODE_CANCEL_ONE = 3'd3;
    localparam logic [2:0] MODE_TICK       = 3'd4;

    // Event codes
    localparam logic [2:0] EV_ACCEPTED  = 3'd0;
    localparam logic [2:0] EV_STARTED   = 3'd1;
    localparam logic [2:0] EV_CANCELLED = 3'd2;
    localparam logic [2:0] EV_REJECTED  = 3'd3;
    localparam logic [2:0] EV_IGNORED   = 3'd4;

    typedef struct packed {
        logic [2:0] mode;
        tag_t       tag;
        logic [7:0] priority_req;
    } req_item_t;

    typedef struct packed {
        logic [2:0] event_res;
        tag_t       event_tag;
        logic       busy_res;
        logic [4:0] queue_count;
        logic       last;
    } evt_item_t;

    typedef struct packed {
        tag_t  tag;
        prio_t prio;
        logic  cancelled;
    } entry_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP,
        OP_MARK
    } cell_op_t;

    // Broadcast from the sequencer to every cell
    typedef struct packed {
        cell_op_t op;
        tag_t     tag;
        prio_t    prio;
    } cell_ctl_t;

    // Handed from one cell to its right neighbor
    typedef struct packed {
        entry_t ent;
        logic   occ;
        logic   shift;
        logic   found;
    } cell_link_t;

endpackage

[sv/spd_cell.sv]
// One queue slot of the dispatcher chain: holds tag, priority and cancel mark.
// Depends on spd_pkg.

module spd_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  spd_pkg::cell_ctl_t ctl,
    input  logic               occ,
    input  spd_pkg::cell_link_t left,
    input  spd_pkg::entry_t    right,
    output spd_pkg::cell_link_t link
);

    spd_pkg::tag_t  tag_reg, tag_next;
    spd_pkg::prio_t prio_reg, prio_next;
    logic           canc_reg, canc_next;
    logic           shift;
    logic           hit;
    logic           take;

    // Strictly worse priority than the newcomer: move one slot right
    assign shift = occ && (prio_reg > ctl.prio);
    // Live entry with the searched tag; only the first one is marked
    assign hit   = occ && !canc_reg && (tag_reg == ctl.tag);
    // Take a value on insert: shifting, or the first free slot
    assign take  = shift || (!occ && left.occ);

    always_comb
    begin
        tag_next  = tag_reg;
        prio_next = prio_reg;
        canc_next = canc_reg;
        case (ctl.op)
            spd_pkg::OP_INSERT:
            begin
                if (take)
                begin
                    if (left.shift)
                    begin
                        tag_next  = left.ent.tag;
                        prio_next = left.ent.prio;
                        canc_next = left.ent.cancelled;
                    end
                    else
                    begin
                        tag_next  = ctl.tag;
                        prio_next = ctl.prio;
                        canc_next = 1'b0;
                    end
                end
            end
            spd_pkg::OP_POP:
            begin
                tag_next  = right.tag;
                prio_next = right.prio;
                canc_next = right.cancelled;
            end
            spd_pkg::OP_MARK:
            begin
                if (hit && !left.found)
                begin
                    canc_next = 1'b1;
                end
            end
            default:
            begin
                canc_next = canc_reg;
            end
        endcase
    end

    // Hand state and flags to the right neighbor
    assign link.ent.tag       = tag_reg;
    assign link.ent.prio      = prio_reg;
    assign link.ent.cancelled = canc_reg;
    assign link.occ           = occ;
    assign link.shift         = shift;
    assign link.found         = left.found || hit;

    // Cancel mark has a defined reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canc_reg <= 1'b0;
        end
        else
        begin
            canc_reg <= canc_next;
        end
    end

    // Payload, meaningful only while occupied
    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        prio_reg <= prio_next;
    end

endmodule

[sv/spd_row.sv]
// Row of spd_cell slots forming the sorted queue, head at slot zero.
// Depends on spd_pkg and spd_cell.

module spd_row (
    input  logic               clk,
    input  logic               rst_n,
    input  spd_pkg::cell_ctl_t ctl,
    input  spd_pkg::cnt_t      count,
    output spd_pkg::entry_t    head,
    output logic               found
);

    spd_pkg::cell_link_t link [spd_pkg::QUEUE_DEPTH+1];

    // Left boundary: always occupied, never shifts, nothing found yet
    assign link[0].ent   = '0;
    assign link[0].occ   = 1'b1;
    assign link[0].shift = 1'b0;
    assign link[0].found = 1'b0;

    for (genvar i = 0; i < spd_pkg::QUEUE_DEPTH; i++)
    begin : g_cell
        logic            occ;
        spd_pkg::entry_t right;

        // Slots below the fill count are occupied
        assign occ = (spd_pkg::cnt_t'(i) < count);

        if (i == spd_pkg::QUEUE_DEPTH - 1)
        begin : g_tail
            assign right = '0;
        end
        else
        begin : g_mid
            assign right = link[i+2].ent;
        end

        spd_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .occ   (occ),
            .left  (link[i]),
            .right (right),
            .link  (link[i+1])
        );
    end

    assign head  = link[1].ent;
    assign found = link[spd_pkg::QUEUE_DEPTH].found;

endmodule

[sv/stable_priority_request_dispatcher_top.sv]
// Top level of the stable priority request dispatcher: sequencer, server state, event register.
// Depends on spd_pkg, spd_row (and spd_cell) and the assertion macro header.
//
//  channel | valid     | ready     | beat type           | role
//  --------+-----------+-----------+---------------------+------------------------------
//  req     | req_valid | req_ready | spd_pkg::req_item_t | enqueue/finish/cancel/tick in
//  evt     | evt_valid | evt_ready | spd_pkg::evt_item_t | event results out
//
// A request is taken only while the sequencer is idle. Each request passes S_EXEC; one that gives a
// single event returns to S_IDLE from there, and an enqueue that starts an idle server passes S_START.
// A finish or a tick passes S_DISP, which drops cancelled heads one at a time; a cancel-all passes
// S_FLUSH, which reports each waiting entry (one event per cycle while evt is not stalled).
// The single event register sets the pace: a stalled evt beat holds the sequencer at each step that emits.
// After reset the queue is empty and the server idle; no clearing pass is needed.

`include "stable_priority_request_dispatcher_top_macros.svh"

module stable_priority_request_dispatcher_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  spd_pkg::req_item_t req_data,
    output logic               evt_valid,
    input  logic               evt_ready,
    output spd_pkg::evt_item_t evt_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_START = 5'b00100,
        S_DISP  = 5'b01000,
        S_FLUSH = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    spd_pkg::req_item_t req_reg, req_next;
    logic               busy_reg, busy_next;
    spd_pkg::tag_t      cur_tag_reg, cur_tag_next;
    spd_pkg::cnt_t      count_reg, count_next;
    logic               evt_valid_reg, evt_valid_next;
    spd_pkg::evt_item_t evt_reg, evt_next;

    logic               evt_free;
    logic               emit;
    spd_pkg::evt_item_t evt_item;
    spd_pkg::cell_ctl_t ctl;
    spd_pkg::entry_t    head;
    logic               found;

    function automatic spd_pkg::evt_item_t mk_evt(
        input logic [2:0]    code,
        input spd_pkg::tag_t tag,
        input logic          busy,
        input spd_pkg::cnt_t cnt,
        input logic          last
    );
        spd_pkg::evt_item_t e;
        e.event_res   = code;
        e.event_tag   = tag;
        e.busy_res    = busy;
        e.queue_count = 5'(cnt);
        e.last        = last;
        return e;
    endfunction

    spd_row u_row (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .count (count_reg),
        .head  (head),
        .found (found)
    );

    assign evt_free  = !evt_valid_reg || evt_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign evt_valid = evt_valid_reg;
    assign evt_data  = evt_reg;

    // Sequencer: one step of the current request per cycle, unless a stalled evt beat holds it
    always_comb
    begin
        state_next   = state_reg;
        busy_next    = busy_reg;
        cur_tag_next = cur_tag_reg;
        count_next   = count_reg;
        emit         = 1'b0;
        evt_item     = '0;
        ctl.op       = spd_pkg::OP_HOLD;
        ctl.tag      = req_reg.tag;
        ctl.prio     = spd_pkg::prio_t'(req_reg.priority_req);

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (req_reg.mode)
                    spd_pkg::MODE_ENQUEUE:
                    begin
                        if (evt_free)
                        begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                            if (count_reg == spd_pkg::cnt_t'(spd_pkg::QUEUE_DEPTH))
                            begin
                                evt_item = mk_evt(spd_pkg::EV_REJECTED, req_reg.tag,
                                                  busy_reg, count_reg, 1'b1);
                            end
                            else if (busy_reg)
                            begin
                                ctl.op     = spd_pkg::OP_INSERT;
                                count_next = count_reg + spd_pkg::cnt_t'(1);
                                evt_item   = mk_evt(spd_pkg::EV_ACCEPTED, req_reg.tag,
                                                    1'b1, count_next, 1'b1);
                            end
                            else
                            begin
                                // Idle server means empty queue: start the newcomer directly
                                evt_item   = mk_evt(spd_pkg::EV_ACCEPTED, req_reg.tag,
                                                    1'b1, '0, 1'b0);
                                state_next = S_START;
                            end
                        end
                    end
                    spd_pkg::MODE_FINISH:
                    begin
                        if (busy_reg && (cur_tag_reg == req_reg.tag))
                        begin
                            busy_next  = 1'b0;
                            state_next = S_DISP;
                        end
                        else if (evt_free)
                        begin
                            emit       = 1'b1;
                            evt_item   = mk_evt(spd_pkg::EV_IGNORED, req_reg.tag,
                                                busy_reg, count_reg, 1'b1);
                            state_next = S_IDLE;
                        end
                    end
                    spd_pkg::MODE_CANCEL_ALL:
                    begin
                        if (!busy_reg)
                        begin
                            state_next = S_FLUSH;
                        end
                        else if (evt_free)
                        begin
                            emit       = 1'b1;
                            evt_item   = mk_evt(spd_pkg::EV_CANCELLED, cur_tag_reg, 1'b0, '0,
                                                count_reg == '0);
                            busy_next  = 1'b0;
                            state_next = S_FLUSH;
                        end
                    end
                    spd_pkg::MODE_CANCEL_ONE:
                    begin
                        if (evt_free)
                        begin
                            ctl.op     = spd_pkg::OP_MARK;
                            emit       = 1'b1;
                            evt_item   = mk_evt(found ? spd_pkg::EV_CANCELLED
                                                      : spd_pkg::EV_IGNORED,
                                                req_reg.tag, busy_reg, count_reg, 1'b1);
                            state_next = S_IDLE;
                        end
                    end
                    spd_pkg::MODE_TICK:
                    begin
                        state_next = S_DISP;
                    end
                    default:
                    begin
                        if (evt_free)
                        begin
                            emit       = 1'b1;
                            evt_item   = mk_evt(spd_pkg::EV_IGNORED, req_reg.tag,
                                                busy_reg, count_reg, 1'b1);
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_START:
            begin
                if (evt_free)
                begin
                    emit         = 1'b1;
                    evt_item     = mk_evt(spd_pkg::EV_STARTED, req_reg.tag, 1'b1, '0, 1'b1);
                    busy_next    = 1'b1;
                    cur_tag_next = req_reg.tag;
                    state_next   = S_IDLE;
                end
            end
            S_DISP:
            begin
                if (busy_reg || (count_reg == '0))
                begin
                    state_next = S_IDLE;
                end
                else if (head.cancelled)
                begin
                    // Drop a cancelled head silently
                    ctl.op     = spd_pkg::OP_POP;
                    count_next = count_reg - spd_pkg::cnt_t'(1);
                end
                else if (evt_free)
                begin
                    ctl.op       = spd_pkg::OP_POP;
                    count_next   = count_reg - spd_pkg::cnt_t'(1);
                    busy_next    = 1'b1;
                    cur_tag_next = head.tag;
                    emit         = 1'b1;
                    evt_item     = mk_evt(spd_pkg::EV_STARTED, head.tag, 1'b1,
                                          count_next, 1'b1);
                    state_next   = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (count_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else if (evt_free)
                begin
                    // Report and drop the head, marked or not
                    ctl.op     = spd_pkg::OP_POP;
                    count_next = count_reg - spd_pkg::cnt_t'(1);
                    emit       = 1'b1;
                    evt_item   = mk_evt(spd_pkg::EV_CANCELLED, head.tag, 1'b0, '0,
                                        count_reg == spd_pkg::cnt_t'(1));
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Capture the request beat
    assign req_next = (req_valid && req_ready) ? req_data : req_reg;

    // Event register: load on emit, drop once taken
    always_comb
    begin
        evt_next       = emit ? evt_item : evt_reg;
        evt_valid_next = evt_valid_reg;
        if (emit)
        begin
            evt_valid_next = 1'b1;
        end
        else if (evt_ready)
        begin
            evt_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= 1'b0;
            cur_tag_reg   <= '0;
            count_reg     <= '0;
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            cur_tag_reg   <= cur_tag_next;
            count_reg     <= count_next;
            evt_valid_reg <= evt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        evt_reg <= evt_next;
    end

    `SPD_ASSERT_IMP(a_idle_server_empty, (state_reg == S_IDLE) && !busy_reg, count_reg == '0, "idle server with waiting entries")
    `SPD_ASSERT_NXT(a_accept_to_exec, req_valid && req_ready, state_reg == S_EXEC, "accepted beat not executed")
    `SPD_ASSERT_NXT(a_start_sets_busy, emit && (evt_item.event_res == spd_pkg::EV_STARTED), busy_reg && (cur_tag_reg == $past(evt_item.event_tag)), "start without busy server")
    `SPD_ASSERT_NXT(a_flush_pops_one, (state_reg == S_FLUSH) && evt_free && (count_reg != '0), count_reg == ($past(count_reg) - spd_pkg::cnt_t'(1)), "flush did not pop one entry")
    `SPD_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= spd_pkg::cnt_t'(spd_pkg::QUEUE_DEPTH), "queue count above depth")

endmodule
